// ===== hdl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, payload types and register codes for the quaternion vector
// rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int VEC_WIDTH  = 24;
  localparam int QUAT_WIDTH = 16;

  // Fraction bits carried by one rotation-matrix entry.
  localparam int FRAC_SHIFT = 2 * (QUAT_WIDTH - 2);

  // Quaternion products (w may be negated, so it is one bit wider).
  localparam int PROD_W = 2 * QUAT_WIDTH + 1;
  // Matrix entries: sums of products, doubled.
  localparam int MAT_W  = PROD_W + 2;
  // Entry times vector component.
  localparam int MUL_W  = MAT_W + VEC_WIDTH;
  // Sum of three products plus rounding bias.
  localparam int ACC_W  = MUL_W + 2;
  // Value after the rounding shift, before clamping.
  localparam int TRIM_W = ACC_W - FRAC_SHIFT;

  localparam logic [QUAT_WIDTH-1:0] QUAT_ONE = QUAT_WIDTH'(1) << (QUAT_WIDTH - 2);

  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) <<< (FRAC_SHIFT - 1);

  localparam logic signed [TRIM_W-1:0] TRIM_MAX =
    {{(TRIM_W - VEC_WIDTH + 1){1'b0}}, {(VEC_WIDTH - 1){1'b1}}};
  localparam logic signed [TRIM_W-1:0] TRIM_MIN = ~TRIM_MAX;

  localparam logic signed [VEC_WIDTH-1:0] VEC_MAX = {1'b0, {(VEC_WIDTH - 1){1'b1}}};
  localparam logic signed [VEC_WIDTH-1:0] VEC_MIN = {1'b1, {(VEC_WIDTH - 1){1'b0}}};

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUAT_X = 2'd0,
    CFG_QUAT_Y = 2'd1,
    CFG_QUAT_Z = 2'd2,
    CFG_QUAT_W = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                        func;
    logic signed [VEC_WIDTH-1:0] in_x;
    logic signed [VEC_WIDTH-1:0] in_y;
    logic signed [VEC_WIDTH-1:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] out_x;
    logic signed [VEC_WIDTH-1:0] out_y;
    logic signed [VEC_WIDTH-1:0] out_z;
    logic                        saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] x;
    logic signed [VEC_WIDTH-1:0] y;
    logic signed [VEC_WIDTH-1:0] z;
  } vec_t;

  // One row of the rotation matrix.
  typedef struct packed {
    logic signed [MAT_W-1:0] c0;
    logic signed [MAT_W-1:0] c1;
    logic signed [MAT_W-1:0] c2;
  } mrow_t;

  // Load enables for the back three pipeline stages.
  typedef struct packed {
    logic en_mul;
    logic en_acc;
    logic en_out;
  } qvr_adv_t;

endpackage

// ===== hdl/qvr_row.sv =====
// ----------------------------------------------------------------------------
// qvr_row
// One output component: row-times-vector multiply, sum with rounding bias,
// then arithmetic shift and clamp to the vector format.
// ----------------------------------------------------------------------------
module qvr_row (
  input  logic                                 clk_i,
  input  qvr_pkg::qvr_adv_t                    adv_i,
  input  qvr_pkg::mrow_t                       row_i,
  input  qvr_pkg::vec_t                        vec_i,
  output logic signed [qvr_pkg::VEC_WIDTH-1:0] val_o,
  output logic                                 sat_o
);
  import qvr_pkg::*;

  logic signed [MUL_W-1:0]     p0_q, p1_q, p2_q;
  logic signed [ACC_W-1:0]     acc_d, acc_q;
  logic signed [TRIM_W-1:0]    trim;
  logic signed [VEC_WIDTH-1:0] val_d, val_q;
  logic                        sat_d, sat_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.en_mul) begin
      p0_q <= MUL_W'(row_i.c0) * MUL_W'(vec_i.x);
      p1_q <= MUL_W'(row_i.c1) * MUL_W'(vec_i.y);
      p2_q <= MUL_W'(row_i.c2) * MUL_W'(vec_i.z);
    end
  end

  assign acc_d = ACC_W'(p0_q) + ACC_W'(p1_q) + ACC_W'(p2_q) + RND_BIAS;

  always_ff @(posedge clk_i) begin
    if (adv_i.en_acc) begin
      acc_q <= acc_d;
    end
  end

  // Round half up happened via the bias; now drop the fraction and clamp.
  assign trim = TRIM_W'(acc_q >>> FRAC_SHIFT);

  always_comb begin
    if (trim > TRIM_MAX) begin
      val_d = VEC_MAX;
      sat_d = 1'b1;
    end else if (trim < TRIM_MIN) begin
      val_d = VEC_MIN;
      sat_d = 1'b1;
    end else begin
      val_d = trim[VEC_WIDTH-1:0];
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en_out) begin
      val_q <= val_d;
      sat_q <= sat_d;
    end
  end

  assign val_o = val_q;
  assign sat_o = sat_q;

endmodule

// ===== hdl/quaternion_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a Q12.12 3-vector by the configured Q2.14 quaternion (or its
// inverse), rounding once at the end and saturating to the vector format.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------
//  in      | input     | in_valid_i / in_stall_o | in_data_i  (in_item_t)
//  out     | output    | out_valid_o/ out_stall_i| out_data_o (out_item_t)
//  cfg     | input     | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// One transaction per cycle unless the output stalls; it passes the
// quaternion products, matrix sums, row multipliers, accumulate and clamp
// stages. Reset clears the valid bits and loads the identity quaternion.
// A stall on the output only holds stages that carry data; empty stages
// keep filling, so in_stall_o rises only when the whole pipe is full.
// Configuration writes are always taken.
//
module quaternion_vector_rotate (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  qvr_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output qvr_pkg::out_item_t               out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [qvr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [qvr_pkg::QUAT_WIDTH-1:0]   cfg_data_i
);
  import qvr_pkg::*;

  typedef struct packed {
    logic signed [PROD_W-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
  } prod_t;

  logic [QUAT_WIDTH-1:0] quat_x_q, quat_y_q, quat_z_q, quat_w_q;

  logic [4:1] valid_q;     // stage 1..4 occupancy
  logic       out_valid_q; // stage 5
  logic [5:1] en;

  logic signed [QUAT_WIDTH-1:0] qx, qy, qz;
  logic signed [QUAT_WIDTH:0]   qw_ext, qw_eff;

  prod_t       prod_d, prod_q;
  vec_t        vec1_q, vec2_q;
  mrow_t [2:0] mat_d, mat_q;
  qvr_adv_t    adv;

  logic signed [VEC_WIDTH-1:0] row_val [3];
  logic                        row_sat [3];

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_x_q <= '0;
      quat_y_q <= '0;
      quat_z_q <= '0;
      quat_w_q <= QUAT_ONE;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_QUAT_X: quat_x_q <= cfg_data_i;
        CFG_QUAT_Y: quat_y_q <= cfg_data_i;
        CFG_QUAT_Z: quat_z_q <= cfg_data_i;
        CFG_QUAT_W: quat_w_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its data moves on
  // --------------------------------------------------------------------------
  always_comb begin
    en[5] = !out_valid_q || !out_stall_i;
    for (int k = 4; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en[1]) valid_q[1] <= in_valid_i;
      for (int k = 2; k <= 4; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
      if (en[5]) out_valid_q <= valid_q[4];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: quaternion products, w negated for the inverse rotation
  // --------------------------------------------------------------------------
  assign qx     = quat_x_q;
  assign qy     = quat_y_q;
  assign qz     = quat_z_q;
  assign qw_ext = {quat_w_q[QUAT_WIDTH-1], quat_w_q};
  assign qw_eff = in_data_i.func ? -qw_ext : qw_ext;

  always_comb begin
    prod_d.xx = PROD_W'(qx) * PROD_W'(qx);
    prod_d.yy = PROD_W'(qy) * PROD_W'(qy);
    prod_d.zz = PROD_W'(qz) * PROD_W'(qz);
    prod_d.ww = PROD_W'(qw_eff) * PROD_W'(qw_eff);
    prod_d.xy = PROD_W'(qx) * PROD_W'(qy);
    prod_d.xz = PROD_W'(qx) * PROD_W'(qz);
    prod_d.yz = PROD_W'(qy) * PROD_W'(qz);
    prod_d.wx = PROD_W'(qw_eff) * PROD_W'(qx);
    prod_d.wy = PROD_W'(qw_eff) * PROD_W'(qy);
    prod_d.wz = PROD_W'(qw_eff) * PROD_W'(qz);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      prod_q   <= prod_d;
      vec1_q.x <= in_data_i.in_x;
      vec1_q.y <= in_data_i.in_y;
      vec1_q.z <= in_data_i.in_z;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: rotation matrix entries
  // --------------------------------------------------------------------------
  always_comb begin
    mat_d[0].c0 = MAT_W'(prod_q.ww) + MAT_W'(prod_q.xx) - MAT_W'(prod_q.yy)
                - MAT_W'(prod_q.zz);
    mat_d[0].c1 = (MAT_W'(prod_q.xy) - MAT_W'(prod_q.wz)) <<< 1;
    mat_d[0].c2 = (MAT_W'(prod_q.xz) + MAT_W'(prod_q.wy)) <<< 1;
    mat_d[1].c0 = (MAT_W'(prod_q.xy) + MAT_W'(prod_q.wz)) <<< 1;
    mat_d[1].c1 = MAT_W'(prod_q.ww) - MAT_W'(prod_q.xx) + MAT_W'(prod_q.yy)
                - MAT_W'(prod_q.zz);
    mat_d[1].c2 = (MAT_W'(prod_q.yz) - MAT_W'(prod_q.wx)) <<< 1;
    mat_d[2].c0 = (MAT_W'(prod_q.xz) - MAT_W'(prod_q.wy)) <<< 1;
    mat_d[2].c1 = (MAT_W'(prod_q.yz) + MAT_W'(prod_q.wx)) <<< 1;
    mat_d[2].c2 = MAT_W'(prod_q.ww) - MAT_W'(prod_q.xx) - MAT_W'(prod_q.yy)
                + MAT_W'(prod_q.zz);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      mat_q  <= mat_d;
      vec2_q <= vec1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3..5: one row unit per output component
  // --------------------------------------------------------------------------
  assign adv.en_mul = en[3];
  assign adv.en_acc = en[4];
  assign adv.en_out = en[5];

  for (genvar r = 0; r < 3; r++) begin : g_row
    qvr_row u_row (
      .clk_i (clk_i),
      .adv_i (adv),
      .row_i (mat_q[r]),
      .vec_i (vec2_q),
      .val_o (row_val[r]),
      .sat_o (row_sat[r])
    );
  end

  assign out_valid_o          = out_valid_q;
  assign out_data_o.out_x     = row_val[0];
  assign out_data_o.out_y     = row_val[1];
  assign out_data_o.out_z     = row_val[2];
  assign out_data_o.saturated = row_sat[0] | row_sat[1] | row_sat[2];

`ifndef SYNTHESIS
  // An empty first stage can always take a transaction.
  a_no_stall_when_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !valid_q[1] |-> !in_stall_o
  ) else $error("input stalled with an empty first stage");

  // Held data in the accumulate stage is not dropped while downstream waits.
  a_acc_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    valid_q[4] && !en[5] |=> valid_q[4]
  ) else $error("accumulate stage lost a transaction under stall");

  // A saturation flag means at least one component sits at a rail.
  a_sat_at_rail: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      (out_data_o.out_x == VEC_MAX) || (out_data_o.out_x == VEC_MIN) ||
      (out_data_o.out_y == VEC_MAX) || (out_data_o.out_y == VEC_MIN) ||
      (out_data_o.out_z == VEC_MAX) || (out_data_o.out_z == VEC_MIN)
  ) else $error("saturation flagged with no clamped component");
`endif

endmodule

// ===== tb/sv/tb_quaternion_vector_rotate.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_vector_rotate
// Self-checking bench for the quaternion vector rotator. A queue-fed driver
// and a monitor run with random gaps and stalls. A bit-exact rotation
// predictor builds the expected vector for every accepted input. The
// quaternion is reprogrammed between phases, once the pipe has drained.
// ----------------------------------------------------------------------------
module tb_quaternion_vector_rotate;
  import qvr_pkg::*;

  localparam int GAP_MAX         = 10;
  localparam int IDLE_LIMIT      = 1000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int RAND_PHASES     = 12;
  localparam int ITEMS_PER_PHASE = 150;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  cfg_idx_e              cfg_index_i = CFG_QUAT_X;
  logic [QUAT_WIDTH-1:0] cfg_data_i  = '0;

  // Local copy of the programmed quaternion.
  logic signed [QUAT_WIDTH-1:0] quat_x_q = '0;
  logic signed [QUAT_WIDTH-1:0] quat_y_q = '0;
  logic signed [QUAT_WIDTH-1:0] quat_z_q = '0;
  logic signed [QUAT_WIDTH-1:0] quat_w_q = QUAT_ONE;

  in_item_t  vec_pending [$];
  out_item_t rotated_q [$];
  out_item_t want_rot;
  int        queued_cnt  = 0;
  int        taken_cnt   = 0;
  int        fail_cnt    = 0;
  int        idle_cycles = 0;
  int        send_hold   = 0;
  int        take_hold   = 0;
  bit        send_burst  = 1'b0;
  bit        take_burst  = 1'b0;

  quaternion_vector_rotate dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Exact R(q) v, single round-half-up at the end, then clamp.
  function automatic out_item_t rotate_expected(in_item_t item);
    longint qx, qy, qz, qw, vx, vy, vz, acc, rnd, vec_hi, vec_lo;
    longint mat [3][3];
    logic [VEC_WIDTH-1:0] comp [3];
    out_item_t res;
    qx = quat_x_q;
    qy = quat_y_q;
    qz = quat_z_q;
    // reverse: negate w exactly, -(-2.0) does not wrap here
    qw = item.func ? -longint'(quat_w_q) : longint'(quat_w_q);
    vx = longint'($signed(item.in_x));
    vy = longint'($signed(item.in_y));
    vz = longint'($signed(item.in_z));
    mat[0][0] = qw*qw + qx*qx - qy*qy - qz*qz;
    mat[0][1] = 2 * (qx*qy - qw*qz);
    mat[0][2] = 2 * (qx*qz + qw*qy);
    mat[1][0] = 2 * (qx*qy + qw*qz);
    mat[1][1] = qw*qw - qx*qx + qy*qy - qz*qz;
    mat[1][2] = 2 * (qy*qz - qw*qx);
    mat[2][0] = 2 * (qx*qz - qw*qy);
    mat[2][1] = 2 * (qy*qz + qw*qx);
    mat[2][2] = qw*qw - qx*qx - qy*qy + qz*qz;
    rnd    = longint'(1) <<< (FRAC_SHIFT - 1);
    vec_hi = longint'(VEC_MAX);
    vec_lo = longint'(VEC_MIN);
    res.saturated = 1'b0;
    for (int r = 0; r < 3; r++) begin
      acc = (mat[r][0]*vx + mat[r][1]*vy + mat[r][2]*vz + rnd) >>> FRAC_SHIFT;
      if (acc > vec_hi) begin
        acc = vec_hi;
        res.saturated = 1'b1;
      end else if (acc < vec_lo) begin
        acc = vec_lo;
        res.saturated = 1'b1;
      end
      comp[r] = acc[VEC_WIDTH-1:0];
    end
    res.out_x = comp[0];
    res.out_y = comp[1];
    res.out_z = comp[2];
    return res;
  endfunction

  // Wait draw per transaction; bursts of back-to-back traffic now and then.
  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic in_item_t mk_vec(logic f, logic [VEC_WIDTH-1:0] vx,
                                      logic [VEC_WIDTH-1:0] vy,
                                      logic [VEC_WIDTH-1:0] vz);
    in_item_t item;
    item.func = f;
    item.in_x = vx;
    item.in_y = vy;
    item.in_z = vz;
    return item;
  endfunction

  function automatic logic [VEC_WIDTH-1:0] pick_comp();
    case ($urandom_range(0, 7))
      4:       return VEC_WIDTH'($urandom_range(0, 65535) - 32768);
      5:       return $urandom_range(0, 1) ? VEC_MAX : VEC_MIN;
      6:       return VEC_WIDTH'($urandom_range(0, 2) - 1);
      default: return VEC_WIDTH'($urandom());
    endcase
  endfunction

  function automatic logic [QUAT_WIDTH-1:0] pick_quat(int kind);
    if (kind == 0) return QUAT_WIDTH'($urandom());
    if (kind == 2) return QUAT_WIDTH'($urandom_range(0, 23170) - 11585);
    case ($urandom_range(0, 4))
      0:       return QUAT_WIDTH'(32767);
      1:       return QUAT_WIDTH'(-32768);
      2:       return '0;
      3:       return QUAT_ONE;
      default: return QUAT_WIDTH'(-16384);
    endcase
  endfunction

  task automatic queue_vec(in_item_t item);
    vec_pending.push_back(item);
    queued_cnt++;
  endtask

  task automatic wait_drained();
    while (taken_cnt != queued_cnt || rotated_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_quat(cfg_idx_e idx, logic [QUAT_WIDTH-1:0] val);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_QUAT_X: quat_x_q = val;
      CFG_QUAT_Y: quat_y_q = val;
      CFG_QUAT_Z: quat_z_q = val;
      CFG_QUAT_W: quat_w_q = val;
      default:    ;
    endcase
  endtask

  task automatic set_quat(logic [QUAT_WIDTH-1:0] qx, logic [QUAT_WIDTH-1:0] qy,
                          logic [QUAT_WIDTH-1:0] qz, logic [QUAT_WIDTH-1:0] qw);
    write_quat(CFG_QUAT_X, qx);
    write_quat(CFG_QUAT_Y, qy);
    write_quat(CFG_QUAT_Z, qz);
    write_quat(CFG_QUAT_W, qw);
  endtask

  // Driver: holds a stalled transaction, otherwise inserts the drawn gap.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        rotated_q.push_back(rotate_expected(in_data_i));
        taken_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_hold > 0) begin
          send_hold--;
          in_valid_i <= 1'b0;
        end else if (vec_pending.size() != 0) begin
          in_data_i  <= vec_pending.pop_front();
          in_valid_i <= 1'b1;
          send_hold = draw_gap(send_burst);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare against the oldest expectation, then draw a stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (rotated_q.size() == 0) begin
          $error("unexpected result: out_x %0d out_y %0d out_z %0d saturated %0b",
                 out_data_o.out_x, out_data_o.out_y, out_data_o.out_z,
                 out_data_o.saturated);
          fail_cnt++;
        end else begin
          want_rot = rotated_q.pop_front();
          if (out_data_o.out_x !== want_rot.out_x) begin
            $error("out_x: expected %0d, got %0d", want_rot.out_x, out_data_o.out_x);
            fail_cnt++;
          end
          if (out_data_o.out_y !== want_rot.out_y) begin
            $error("out_y: expected %0d, got %0d", want_rot.out_y, out_data_o.out_y);
            fail_cnt++;
          end
          if (out_data_o.out_z !== want_rot.out_z) begin
            $error("out_z: expected %0d, got %0d", want_rot.out_z, out_data_o.out_z);
            fail_cnt++;
          end
          if (out_data_o.saturated !== want_rot.saturated) begin
            $error("saturated: expected %0b, got %0b", want_rot.saturated,
                   out_data_o.saturated);
            fail_cnt++;
          end
        end
        take_hold = draw_gap(take_burst);
      end
      if (take_hold > 0) begin
        take_hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity quaternion straight out of reset
    queue_vec(mk_vec(1'b0, VEC_MAX, VEC_MIN, '0));
    queue_vec(mk_vec(1'b1, VEC_MAX, VEC_MIN, '0));
    queue_vec(mk_vec(1'b0, VEC_MIN, VEC_MAX, 24'sd1));
    queue_vec(mk_vec(1'b1, '0, '0, '0));
    queue_vec(mk_vec(1'b0, 24'sd1, -24'sd1, 24'sd4096));
    queue_vec(mk_vec(1'b1, -24'sd1, 24'sd1, -24'sd4096));
    queue_vec(mk_vec(1'b0, VEC_MAX, VEC_MAX, VEC_MAX));
    queue_vec(mk_vec(1'b1, VEC_MIN, VEC_MIN, VEC_MIN));
    queue_vec(mk_vec(1'b0, 24'h555555, 24'haaaaaa, 24'h0f0f0f));
    queue_vec(mk_vec(1'b1, 24'haaaaaa, 24'h555555, 24'hf0f0f0));
    wait_drained();

    // most negative components: reverse negates w = -2.0, heavy clamping
    set_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    queue_vec(mk_vec(1'b0, VEC_MAX, VEC_MAX, VEC_MAX));
    queue_vec(mk_vec(1'b1, VEC_MAX, VEC_MAX, VEC_MAX));
    queue_vec(mk_vec(1'b0, 24'sd1, '0, '0));
    queue_vec(mk_vec(1'b1, VEC_MIN, '0, 24'sd1));
    queue_vec(mk_vec(1'b1, '0, -24'sd1, VEC_MIN));
    wait_drained();

    set_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    queue_vec(mk_vec(1'b0, VEC_MIN, VEC_MAX, '0));
    queue_vec(mk_vec(1'b1, VEC_MIN, VEC_MAX, '0));
    queue_vec(mk_vec(1'b0, -24'sd1, 24'sd1, 24'sd1));
    queue_vec(mk_vec(1'b1, 24'sd4096, -24'sd4096, '0));
    queue_vec(mk_vec(1'b0, VEC_MAX, VEC_MIN, VEC_MAX));
    wait_drained();

    // w = 0.5 scales by 1/4: exact half-lsb ties round toward +inf
    set_quat('0, '0, '0, 16'sd8192);
    queue_vec(mk_vec(1'b0, 24'sd2, -24'sd2, 24'sd6));
    queue_vec(mk_vec(1'b1, -24'sd6, 24'sd1, -24'sd1));
    queue_vec(mk_vec(1'b0, 24'sd3, -24'sd3, '0));
    queue_vec(mk_vec(1'b1, VEC_MAX, VEC_MIN, -24'sd2));
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      set_quat(pick_quat(p % 3), pick_quat(p % 3), pick_quat(p % 3), pick_quat(p % 3));
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        queue_vec(mk_vec(1'($urandom_range(0, 1)), pick_comp(), pick_comp(), pick_comp()));
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/qvr_pkg.sv
hdl/qvr_row.sv
hdl/quaternion_vector_rotate.sv
tb/sv/tb_quaternion_vector_rotate.sv
